/* hdl/cfpt_pkg.sv */
// ----------------------------------------------------------------------------
// cfpt_pkg
// Shared widths and defaults for the clock follow phase tracker.
// ----------------------------------------------------------------------------
package cfpt_pkg;

	localparam int FRACTION_BITS_DEF = 32;
	localparam int TIME_BITS_DEF     = 48;

	localparam int POS_BITS     = 64;
	localparam int COUNT_BITS   = 32;
	localparam int WHOLE_BITS   = 32;
	localparam int RATE_OUT_BITS = 33;
	localparam int TIME_IN_BITS = 48;

	localparam int GAIN_BITS = 4;
	localparam logic [GAIN_BITS-1:0] GAIN_RESET = 4'd2;

	localparam int IN_DATA_BITS  = 48;
	localparam int OUT_DATA_BITS = 72;

	localparam logic OP_PULSE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

endpackage

/* hdl/clock_follow_phase_tracker_unit.sv */
// Pulse event: restoring division (one quotient bit per cycle), then the
// result is applied in ST_APPLY and presented in ST_FINISH once the output is free.
// Update tick: shift-add multiply (one bit of the elapsed time per cycle),
// then the result is presented in ST_FINISH once the output is free.
// First pulse and ignored ticks go straight to ST_FINISH. One event is in work at a time.
// Reset clears all tracking state; gain_shift returns to 2.
// ----------------------------------------------------------------------------
// clock_follow_phase_tracker_unit
// Follows an external clock from timestamped pulse and update events.
// ----------------------------------------------------------------------------
module clock_follow_phase_tracker_unit
	import cfpt_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int TIME_BITS     = TIME_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [GAIN_BITS-1:0]      cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_DATA_BITS-1:0]   s_tdata,  // [47:0] time_us
	input  logic                      s_tuser,  // [0] op
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [0] beat_trigger, [32:1] position_whole, [65:33] rate_q32, [66] locked,
	// [71:67] zero
	output logic [OUT_DATA_BITS-1:0]  m_tdata
);

	localparam int RATE_BITS = FRACTION_BITS + 1;
	localparam int INT_BITS  = POS_BITS - FRACTION_BITS;
	localparam int MAX_STEPS = (RATE_BITS > TIME_BITS) ? RATE_BITS : TIME_BITS;
	localparam int CNT_W     = $clog2(MAX_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_APPLY,
		ST_MULT,
		ST_FINISH
	} state_t;

	state_t                  state_q;
	logic [GAIN_BITS-1:0]    gain_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [POS_BITS-1:0]     pos_q;
	logic [RATE_BITS-1:0]    rate_q;
	logic [TIME_BITS-1:0]    last_update_q;
	logic [TIME_BITS-1:0]    last_pulse_q;
	logic                    first_seen_q;
	logic                    armed_q;
	logic                    tick_q;
	logic [CNT_W-1:0]        cnt_q;

	// working registers of the serial divider and multiplier
	logic [TIME_BITS-1:0]    div_q;
	logic [TIME_BITS-1:0]    rem_q;
	logic [RATE_BITS-1:0]    quo_q;
	logic [POS_BITS-1:0]     mcand_q;
	logic [TIME_BITS-1:0]    mplier_q;
	logic [INT_BITS-1:0]     before_q;
	logic [TIME_BITS-1:0]    now_hold_q;

	logic [TIME_BITS-1:0]    now_in;
	logic [TIME_BITS-1:0]    period;
	logic [TIME_BITS-1:0]    delta;
	logic                    accept;
	logic                    dbit;
	logic [TIME_BITS:0]      rem_sh;
	logic [TIME_BITS:0]      rem_diff;
	logic                    rem_ge;
	logic [COUNT_BITS-1:0]   next_count;
	logic [COUNT_BITS-1:0]   diff;
	logic                    diff_neg;
	logic [COUNT_BITS-1:0]   mag;
	logic [POS_BITS-1:0]     corr;
	logic                    trig;
	logic                    out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	assign now_in = TIME_BITS'(s_tdata[TIME_IN_BITS-1:0]);
	assign period = now_in - last_pulse_q;
	assign delta  = now_in - last_update_q;
	assign next_count = count_q + COUNT_BITS'(1);

	// dividend is 2^FRACTION_BITS: a single one at the top step
	assign dbit     = (cnt_q == CNT_W'(FRACTION_BITS));
	assign rem_sh   = {rem_q, dbit};
	assign rem_diff = rem_sh - {1'b0, div_q};
	assign rem_ge   = !rem_diff[TIME_BITS];

	assign diff     = count_q - pos_q[FRACTION_BITS+WHOLE_BITS-1:FRACTION_BITS];
	assign diff_neg = diff[COUNT_BITS-1];
	assign mag      = diff_neg ? (COUNT_BITS'(0) - diff) : diff;
	assign corr     = (POS_BITS'(mag) << FRACTION_BITS) >> gain_q;

	assign trig = tick_q && ($signed(pos_q[POS_BITS-1:FRACTION_BITS]) > $signed(before_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			gain_q        <= GAIN_RESET;
			count_q       <= '0;
			pos_q         <= '0;
			rate_q        <= '0;
			last_update_q <= '0;
			last_pulse_q  <= '0;
			first_seen_q  <= 1'b0;
			armed_q       <= 1'b0;
			tick_q        <= 1'b0;
			cnt_q         <= '0;
			m_tvalid      <= 1'b0;
			m_tdata       <= '0;
		end else begin
			if (cfg_we) begin
				gain_q <= cfg_wdata;
			end
			// the finish state loads the next result itself
			if (m_tvalid && m_tready && state_q != ST_FINISH) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tick_q <= 1'b0;
						if (s_tuser == OP_PULSE) begin
							count_q      <= next_count;
							last_pulse_q <= now_in;
							if (!first_seen_q) begin
								first_seen_q <= 1'b1;
								state_q      <= ST_FINISH;
							end else begin
								cnt_q   <= CNT_W'(FRACTION_BITS);
								state_q <= ST_DIVIDE;
							end
						end else if (armed_q) begin
							tick_q        <= 1'b1;
							last_update_q <= now_in;
							cnt_q         <= CNT_W'(TIME_BITS - 1);
							state_q       <= ST_MULT;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_DIVIDE: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					rate_q <= quo_q;
					if (!armed_q) begin
						pos_q         <= POS_BITS'(count_q) << FRACTION_BITS;
						armed_q       <= 1'b1;
						last_update_q <= now_hold_q;
					end else if (diff_neg) begin
						pos_q <= pos_q - corr;
					end else begin
						pos_q <= pos_q + corr;
					end
					state_q <= ST_FINISH;
				end
				ST_MULT: begin
					// add the shifted rate for each set bit of the elapsed time
					if (mplier_q[0]) begin
						pos_q <= pos_q + mcand_q;
					end
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {5'd0, armed_q, RATE_OUT_BITS'(rate_q),
							pos_q[FRACTION_BITS+WHOLE_BITS-1:FRACTION_BITS], trig};
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				now_hold_q <= now_in;
				div_q      <= (period == '0) ? TIME_BITS'(1) : period;
				rem_q      <= '0;
				quo_q      <= '0;
				mcand_q    <= POS_BITS'(rate_q);
				mplier_q   <= delta;
				before_q   <= pos_q[POS_BITS-1:FRACTION_BITS];
			end
			ST_DIVIDE: begin
				rem_q <= rem_ge ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
				quo_q <= {quo_q[RATE_BITS-2:0], rem_ge};
			end
			ST_MULT: begin
				mcand_q  <= {mcand_q[POS_BITS-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[TIME_BITS-1:1]};
			end
			default: begin
				div_q <= div_q;
			end
		endcase
	end

endmodule
